// File: rtl/core/email_address_syntax_checker_assert.svh
// Assertion helpers for the address checker. All checks are sampled on the
// rising edge of clk and are off while rst_n is low.
`ifndef EMAIL_ADDRESS_SYNTAX_CHECKER_ASSERT_SVH
`define EMAIL_ADDRESS_SYNTAX_CHECKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/esc_pkg.sv
package esc_pkg;

  localparam int CHAR_W      = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 4 - CHAR_W;

  localparam logic [CHAR_W-1:0] CH_AT         = 8'h40;
  localparam logic [CHAR_W-1:0] CH_DOT        = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_HYPHEN     = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_BANG       = 8'h21;
  localparam logic [CHAR_W-1:0] CH_HASH       = 8'h23;
  localparam logic [CHAR_W-1:0] CH_DOLLAR     = 8'h24;
  localparam logic [CHAR_W-1:0] CH_PERCENT    = 8'h25;
  localparam logic [CHAR_W-1:0] CH_AMPERSAND  = 8'h26;
  localparam logic [CHAR_W-1:0] CH_QUOTE      = 8'h27;
  localparam logic [CHAR_W-1:0] CH_STAR       = 8'h2A;

  localparam logic [1:0] AT_NONE = 2'd0;
  localparam logic [1:0] AT_ONE  = 2'd1;
  localparam logic [1:0] AT_MANY = 2'd2;

  typedef enum logic [3:0] {
    VRD_OK,
    VRD_EMPTY,
    VRD_NO_AT,
    VRD_MULTI_AT,
    VRD_EMPTY_LOCAL,
    VRD_LOCAL_LEAD_DOT,
    VRD_LOCAL_TRAIL_DOT,
    VRD_LOCAL_BAD_CHAR,
    VRD_EMPTY_DOMAIN,
    VRD_DOMAIN_LEAD_HYPHEN,
    VRD_DOMAIN_TRAIL_HYPHEN,
    VRD_NO_DOT,
    VRD_EMPTY_LABEL,
    VRD_DOMAIN_BAD_CHAR
  } verdict_t;

  typedef enum logic [1:0] {
    DERR_NONE,
    DERR_EMPTY_LABEL,
    DERR_BAD_CHAR
  } derr_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
    logic              empty;
  } in_item_t;

  typedef struct packed {
    verdict_t          verdict;
    logic [CHAR_W-1:0] bad_char;
  } result_t;

  typedef struct packed {
    logic [1:0]        at_count;
    logic              local_seen_char;
    logic              local_lead_dot;
    logic              local_trail_dot;
    logic [CHAR_W-1:0] previous_char;
    logic              local_bad_found;
    logic [CHAR_W-1:0] local_bad_char;
    logic              domain_seen_char;
    logic              domain_lead_hyphen;
    logic              domain_dot_seen;
    logic              label_empty_so_far;
    derr_t             domain_first_error;
    logic [CHAR_W-1:0] domain_bad_char;
  } track_t;

  localparam track_t TRACK_RESET = '{
    at_count:           AT_NONE,
    local_seen_char:    1'b0,
    local_lead_dot:     1'b0,
    local_trail_dot:    1'b0,
    previous_char:      '0,
    local_bad_found:    1'b0,
    local_bad_char:     '0,
    domain_seen_char:   1'b0,
    domain_lead_hyphen: 1'b0,
    domain_dot_seen:    1'b0,
    label_empty_so_far: 1'b1,
    domain_first_error: DERR_NONE,
    domain_bad_char:    '0
  };

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic local_ok(input logic [CHAR_W-1:0] c);
    return is_alnum(c) || c == CH_UNDERSCORE || c == CH_HYPHEN || c == CH_DOT ||
           c == CH_BANG || c == CH_HASH || c == CH_DOLLAR || c == CH_PERCENT ||
           c == CH_AMPERSAND || c == CH_QUOTE || c == CH_STAR;
  endfunction

  // Folds one character into the running flags.
  function automatic track_t take_char(input track_t s, input logic [CHAR_W-1:0] c);
    track_t n;
    n = s;
    if (c == CH_AT) begin
      if (s.at_count == AT_NONE) begin
        n.local_trail_dot = s.local_seen_char && (s.previous_char == CH_DOT);
      end
      if (s.at_count != AT_MANY) begin
        n.at_count = s.at_count + 2'd1;
      end
    end else if (s.at_count == AT_NONE) begin
      if (!s.local_seen_char) begin
        n.local_lead_dot = (c == CH_DOT);
      end
      n.local_seen_char = 1'b1;
      if (!s.local_bad_found && !local_ok(c)) begin
        n.local_bad_found = 1'b1;
        n.local_bad_char  = c;
      end
    end else if (s.at_count == AT_ONE) begin
      if (!s.domain_seen_char) begin
        n.domain_lead_hyphen = (c == CH_HYPHEN);
      end
      n.domain_seen_char = 1'b1;
      if (c == CH_DOT) begin
        n.domain_dot_seen = 1'b1;
        if (s.label_empty_so_far && s.domain_first_error == DERR_NONE) begin
          n.domain_first_error = DERR_EMPTY_LABEL;
        end
        n.label_empty_so_far = 1'b1;
      end else begin
        if (s.domain_first_error == DERR_NONE && !is_alnum(c) && c != CH_HYPHEN) begin
          n.domain_first_error = DERR_BAD_CHAR;
          n.domain_bad_char    = c;
        end
        n.label_empty_so_far = 1'b0;
      end
    end
    n.previous_char = c;
    return n;
  endfunction

  // Priority chain of the checks, taken on the flags after the final character.
  function automatic result_t finish(input track_t s);
    result_t r;
    r.verdict  = VRD_OK;
    r.bad_char = '0;
    if (s.at_count == AT_NONE) begin
      r.verdict = VRD_NO_AT;
    end else if (s.at_count == AT_MANY) begin
      r.verdict = VRD_MULTI_AT;
    end else if (!s.local_seen_char) begin
      r.verdict = VRD_EMPTY_LOCAL;
    end else if (s.local_lead_dot) begin
      r.verdict = VRD_LOCAL_LEAD_DOT;
    end else if (s.local_trail_dot) begin
      r.verdict = VRD_LOCAL_TRAIL_DOT;
    end else if (s.local_bad_found) begin
      r.verdict  = VRD_LOCAL_BAD_CHAR;
      r.bad_char = s.local_bad_char;
    end else if (!s.domain_seen_char) begin
      r.verdict = VRD_EMPTY_DOMAIN;
    end else if (s.domain_lead_hyphen) begin
      r.verdict = VRD_DOMAIN_LEAD_HYPHEN;
    end else if (s.previous_char == CH_HYPHEN) begin
      r.verdict = VRD_DOMAIN_TRAIL_HYPHEN;
    end else if (!s.domain_dot_seen) begin
      r.verdict = VRD_NO_DOT;
    end else if (s.domain_first_error == DERR_EMPTY_LABEL ||
                 (s.domain_first_error == DERR_NONE && s.label_empty_so_far)) begin
      // A trailing dot leaves the last label empty.
      r.verdict = VRD_EMPTY_LABEL;
    end else if (s.domain_first_error == DERR_BAD_CHAR) begin
      r.verdict  = VRD_DOMAIN_BAD_CHAR;
      r.bad_char = s.domain_bad_char;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/esc_in_stage.sv
module esc_in_stage import esc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,
  input  logic              in_tlast,
  input  logic              in_tuser,
  output logic              item_valid,
  output in_item_t          item,
  input  logic              item_take
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_tready = !valid_r || item_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.char_code <= in_tdata;
      item_r.last      <= in_tlast;
      item_r.empty     <= in_tuser;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: rtl/core/esc_track.sv
module esc_track import esc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     item_valid,
  input  in_item_t item,
  input  logic     out_free,
  output logic     item_take,
  output logic     res_load,
  output result_t  res
);

  track_t state_r;
  track_t state_nxt;
  track_t stepped;
  logic   is_final;

  // Only a final item needs room in the output register.
  assign is_final  = item.last || item.empty;
  assign item_take = item_valid && (!is_final || out_free);
  assign res_load  = item_take && is_final;

  assign stepped = take_char(state_r, item.char_code);

  always_comb begin
    if (item.empty) begin
      res.verdict  = VRD_EMPTY;
      res.bad_char = '0;
    end else begin
      res = finish(stepped);
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (item_take) begin
      state_nxt = is_final ? TRACK_RESET : stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TRACK_RESET;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/esc_out_stage.sv
module esc_out_stage import esc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_load,
  input  result_t                res,
  output logic                   out_free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign out_free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, res_r.bad_char, res_r.verdict};

endmodule

// File: rtl/core/email_address_syntax_checker.sv
// Email address syntax checker.
// The in_ channel carries an address one character per request: in_tdata is
// the character, in_tlast marks its final character, and in_tuser set marks
// a request that stands for a whole empty address (it also ends the address).
// No result is given for a character that is not final. For each final or
// empty request, one result leaves on the out_ channel: a verdict code in
// out_tdata[3:0] and the offending character in out_tdata[11:4].
// One character is taken every cycle unless a final character waits for room
// in the output register. Each request is held in an input register; from
// there its flag update and verdict are computed and the result is loaded
// into the output register, which drives out_tvalid.
// While the receiver stalls, characters that are not final keep flowing;
// a final character waits in the input register until the output register
// is free, which then also holds back in_tready.
// A synchronous reset (rst_n low) empties both registers and clears the flags.
`include "email_address_syntax_checker_assert.svh"

module email_address_syntax_checker import esc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [CHAR_W-1:0]      in_tdata,   // [7:0] char_code
  input  logic                   in_tlast,
  input  logic                   in_tuser,   // [0] empty_string
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [3:0] verdict, [11:4] bad_char
);

  logic     item_valid;
  in_item_t item;
  logic     item_take;
  logic     item_final;
  logic     out_free;
  logic     res_load;
  result_t  res;

  esc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  esc_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .item_take  (item_take),
    .res_load   (res_load),
    .res        (res)
  );

  esc_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_load   (res_load),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  assign item_final = item.last || item.empty;

  `ESC_ASSERT_NEXT(a_result_only_from_final, !(item_take && item_final), !$rose(out_tvalid), "result appeared without a final character")
  `ESC_ASSERT_SAME(a_verdict_range, out_tvalid, out_tdata[3:0] <= VRD_DOMAIN_BAD_CHAR, "verdict code out of range")
  `ESC_ASSERT_SAME(a_bad_char_verdict, out_tvalid && out_tdata[11:4] != 8'h00, out_tdata[3:0] == VRD_LOCAL_BAD_CHAR || out_tdata[3:0] == VRD_DOMAIN_BAD_CHAR, "offending character given with a verdict that has none")

endmodule
